[sv/dfd_pkg.sv]
package dfd_pkg;

  // Frame layout
  localparam int NUM_VALUES  = 5;
  localparam int PAYLOAD_LEN = 2 * NUM_VALUES;
  localparam int FRAME_LEN   = PAYLOAD_LEN + 5;
  localparam int FILL_W      = $clog2(FRAME_LEN + 1);
  localparam int DUTY_W      = 10;

  localparam logic [7:0]        CRC_POLY = 8'h07;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1023;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER_FIRST  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER_SECOND = 2'd3;

  localparam logic [7:0] RST_HEADER_FIRST  = 8'hAA;
  localparam logic [7:0] RST_HEADER_SECOND = 8'h55;
  localparam logic [7:0] RST_FOOTER_FIRST  = 8'h55;
  localparam logic [7:0] RST_FOOTER_SECOND = 8'hAA;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       new_buffer;
  } dfd_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_0;
    logic [DUTY_W-1:0] duty_1;
    logic [DUTY_W-1:0] duty_2;
    logic [DUTY_W-1:0] duty_3;
    logic [DUTY_W-1:0] duty_4;
  } dfd_out_t;

  // What one cell hands to its older neighbor
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] crc;
  } dfd_link_t;

  // One byte through the MSB-first CRC-8 register (caller XORs the byte in)
  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in);
    logic [7:0] c;
    c = crc_in;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Little-endian 16-bit value, saturated to the duty range
  function automatic logic [DUTY_W-1:0] clamp_duty(input logic [7:0] lo,
                                                   input logic [7:0] hi);
    if (hi[7:2] != 6'd0) return DUTY_MAX;
    else                 return {hi[1:0], lo};
  endfunction

endpackage

[sv/dfd_cell.sv]
module dfd_cell #(
  parameter bit ABSORB = 1'b1
) (
  input  logic              clk,
  input  logic              adv,
  input  logic [7:0]        new_byte,
  input  dfd_pkg::dfd_link_t prev,
  output dfd_pkg::dfd_link_t cur
);
  import dfd_pkg::*;

  dfd_link_t cur_r;
  dfd_link_t cur_nxt;

  // Shift the byte one age older; absorb the arriving byte into the CRC
  // while this cell still lies inside the payload span, else pass it on.
  always_comb begin
    cur_nxt.data = prev.data;
    if (ABSORB) cur_nxt.crc = crc8_step(prev.crc ^ new_byte);
    else        cur_nxt.crc = prev.crc;
  end

  always_ff @(posedge clk) begin
    if (adv) cur_r <= cur_nxt;
  end

  assign cur = cur_r;

endmodule

[sv/duty_frame_deframer_crc8_core.sv]
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall   | dfd_in_t  (byte_value, new_buffer)
// out_    | output    | out_valid / out_stall | dfd_out_t (duty_0 .. duty_4)
// cfg_    | input     | APB, pready tied high | header/footer marker bytes
//
// One byte is taken per cycle, back to back, unless in_stall holds it; a result is
// registered once the byte that completes a good frame is in the cell chain. The rate
// is set by the cell chain, which shifts one byte and one CRC step per cell per accepted byte.
// Reset (rst_n low, synchronous) empties the window and restores the markers.
// A stalled result stalls the input only when a further good frame is waiting.
module duty_frame_deframer_crc8_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dfd_pkg::dfd_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dfd_pkg::dfd_out_t  out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import dfd_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] hdr0_r, hdr1_r, ftr0_r, ftr1_r;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr0_r <= RST_HEADER_FIRST;
      hdr1_r <= RST_HEADER_SECOND;
      ftr0_r <= RST_FOOTER_FIRST;
      ftr1_r <= RST_FOOTER_SECOND;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HEADER_FIRST:  hdr0_r <= cfg_pwdata[7:0];
        REG_HEADER_SECOND: hdr1_r <= cfg_pwdata[7:0];
        REG_FOOTER_FIRST:  ftr0_r <= cfg_pwdata[7:0];
        REG_FOOTER_SECOND: ftr1_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HEADER_FIRST:  cfg_prdata = {24'd0, hdr0_r};
      REG_HEADER_SECOND: cfg_prdata = {24'd0, hdr1_r};
      REG_FOOTER_FIRST:  cfg_prdata = {24'd0, ftr0_r};
      REG_FOOTER_SECOND: cfg_prdata = {24'd0, ftr1_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake and evaluation stage
  // ---------------------------------------------------------------------------
  logic in_accept;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_hit, out_blocked;
  logic frame_ok;

  assign out_blocked = out_valid && out_stall;
  assign s1_hit      = s1_valid_r && frame_ok;
  // Hold the window only while a good frame waits behind a stalled result.
  assign in_stall    = s1_hit && out_blocked;
  assign in_accept   = in_valid && !in_stall;

  always_comb begin
    if (in_accept)     s1_valid_nxt = 1'b1;
    else if (in_stall) s1_valid_nxt = s1_valid_r;
    else               s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  // ---------------------------------------------------------------------------
  // Fill count: bytes held since the start of the buffer, saturating
  // ---------------------------------------------------------------------------
  logic [FILL_W-1:0] fill_r, fill_nxt;

  always_comb begin
    fill_nxt = fill_r;
    if (in_accept) begin
      if (in_data.new_buffer)                       fill_nxt = FILL_W'(1);
      else if (fill_r != FILL_W'(FRAME_LEN))        fill_nxt = fill_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fill_r <= '0;
    else        fill_r <= fill_nxt;
  end

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 holds the newest byte, cell FRAME_LEN-1 the oldest.
  // Cell c (c < PAYLOAD_LEN) holds the CRC over the newest c+1 bytes; later
  // cells delay that CRC so it lines up with the payload span of the window.
  // ---------------------------------------------------------------------------
  dfd_link_t link_in;
  dfd_link_t link [FRAME_LEN];

  assign link_in = '{data: in_data.byte_value, crc: 8'h00};

  for (genvar c = 0; c < FRAME_LEN; c++) begin : g_cell
    if (c == 0) begin : g_head
      dfd_cell #(.ABSORB(1'b1)) u_cell (
        .clk      (clk),
        .adv      (in_accept),
        .new_byte (in_data.byte_value),
        .prev     (link_in),
        .cur      (link[c])
      );
    end else begin : g_body
      dfd_cell #(.ABSORB(c < PAYLOAD_LEN)) u_cell (
        .clk      (clk),
        .adv      (in_accept),
        .new_byte (in_data.byte_value),
        .prev     (link[c-1]),
        .cur      (link[c])
      );
    end
  end

  // Frame check on the registered window; ages count from the newest byte.
  localparam int AGE_HDR0 = FRAME_LEN - 1;
  localparam int AGE_HDR1 = FRAME_LEN - 2;
  localparam int AGE_CRC  = 2;
  localparam int AGE_FTR0 = 1;
  localparam int AGE_FTR1 = 0;
  localparam int AGE_PAY0 = FRAME_LEN - 3;   // first payload byte
  localparam int CRC_CELL = AGE_PAY0;        // CRC over the payload span

  assign frame_ok = (fill_r == FILL_W'(FRAME_LEN))
                 && (link[AGE_HDR0].data == hdr0_r)
                 && (link[AGE_HDR1].data == hdr1_r)
                 && (link[AGE_FTR0].data == ftr0_r)
                 && (link[AGE_FTR1].data == ftr1_r)
                 && (link[CRC_CELL].crc  == link[AGE_CRC].data);

  dfd_out_t result;
  assign result.duty_0 = clamp_duty(link[AGE_PAY0].data,     link[AGE_PAY0 - 1].data);
  assign result.duty_1 = clamp_duty(link[AGE_PAY0 - 2].data, link[AGE_PAY0 - 3].data);
  assign result.duty_2 = clamp_duty(link[AGE_PAY0 - 4].data, link[AGE_PAY0 - 5].data);
  assign result.duty_3 = clamp_duty(link[AGE_PAY0 - 6].data, link[AGE_PAY0 - 7].data);
  assign result.duty_4 = clamp_duty(link[AGE_PAY0 - 8].data, link[AGE_PAY0 - 9].data);

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic     out_valid_r;
  dfd_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_hit && !out_blocked) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_hit && !out_blocked) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_result_needs_full_window: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(fill_r) == FILL_W'(FRAME_LEN)))
    else $error("result issued from a partial window");

  a_accept_reaches_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted byte not presented to the frame check");

endmodule
